@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every rising clock edge, also during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hdl/sdt_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the SDT service descriptor parser
package sdt_pkg;

  localparam logic [7:0]  SVC_DESC_TAG       = 8'h48;
  localparam logic [7:0]  LEN_NIBBLE_MASK    = 8'h0F;
  localparam logic [11:0] MIN_SECTION_LENGTH = 12'd17;
  localparam logic [7:0]  FIRST_SVC_BYTE_POS = 8'd10;

  typedef enum logic [1:0] {
    KIND_NAME  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [10:0] {
    PH_IDLE    = 11'b000_0000_0001,
    PH_HDR     = 11'b000_0000_0010,
    PH_SID_HI  = 11'b000_0000_0100,
    PH_SID_LO  = 11'b000_0000_1000,
    PH_FLAGS   = 11'b000_0001_0000,
    PH_LOOP_HI = 11'b000_0010_0000,
    PH_LOOP_LO = 11'b000_0100_0000,
    PH_TAG     = 11'b000_1000_0000,
    PH_LEN     = 11'b001_0000_0000,
    PH_BODY    = 11'b010_0000_0000,
    PH_DONE    = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [15:0] service_id;
    logic [7:0]  name_byte;
    logic        last;
  } result_t;

endpackage

@@ hdl/sdt_service_descriptor_parser.sv @@
`timescale 1ns / 1ps
// Top level of the SDT service descriptor parser
//
//   channel  direction  handshake              payload
//   input    in         in_valid / in_ready    data_byte, first_byte
//   result   out        out_valid / out_ready  kind, service_id, name_byte, last
//   config   in         wr_en                  wr_data (wanted service type)
//
// One section byte is taken per cycle while results are not stalled; its
// result, if any, is loaded into the result register as the parser takes it.
// The rate is set by the single parser state update per byte.
// rst is synchronous and clears the parse state; wanted type resets to 1.
// A stalled result holds the parser, which then holds the input register.
`include "assert_macros.svh"

module sdt_service_descriptor_parser #(
  parameter int MAX_SECTION_LENGTH = 1021
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        wr_en,
  input  logic [7:0]  wr_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [15:0] service_id,
  output logic [7:0]  name_byte,
  output logic        last
);

  logic             held_valid;
  logic [7:0]       held_byte;
  logic             held_first;
  logic             advance;
  logic [7:0]       wanted_service_type;
  sdt_pkg::result_t res;

  // advance the held item whenever the result register can take a result
  assign advance = held_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_service_type <= 8'd1;
    end else if (wr_en) begin
      wanted_service_type <= wr_data;
    end
  end

  sdt_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .first_byte (first_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .held_first (held_first)
  );

  sdt_parse_core #(
    .MAX_SECTION_LENGTH (MAX_SECTION_LENGTH)
  ) u_core (
    .clk                 (clk),
    .rst                 (rst),
    .advance             (advance),
    .data_byte           (held_byte),
    .first_byte          (held_first),
    .wanted_service_type (wanted_service_type),
    .res                 (res)
  );

  sdt_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && res.valid),
    .res        (res),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .service_id (service_id),
    .name_byte  (name_byte),
    .last       (last)
  );

  `ASSERT_CLK(a_kind_code, clk, rst, out_valid |-> (kind == sdt_pkg::KIND_NAME || kind == sdt_pkg::KIND_EMPTY || kind == sdt_pkg::KIND_ERROR), "result kind out of range")
  `ASSERT_CLK(a_error_form, clk, rst, (out_valid && kind == sdt_pkg::KIND_ERROR) |-> (last && service_id == 16'd0 && name_byte == 8'd0), "bad length result malformed")
  `ASSERT_CLK(a_empty_last, clk, rst, (out_valid && kind == sdt_pkg::KIND_EMPTY) |-> (last && name_byte == 8'd0), "empty name result malformed")
  `ASSERT_CLK(a_stall_holds, clk, rst, (held_valid && out_valid && !out_ready) |-> !in_ready, "input taken while parser stalled")

endmodule

@@ hdl/sdt_in_stage.sv @@
`timescale 1ns / 1ps
// Input register: holds one section byte until the parser takes it
module sdt_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       first_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte,
  output logic       held_first
);

  logic accept;

  assign in_ready = !held_valid || advance;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_byte  <= data_byte;
      held_first <= first_byte;
    end
  end

endmodule

@@ hdl/sdt_parse_core.sv @@
`timescale 1ns / 1ps
// Section walker: header length check, service loop and descriptor decode
module sdt_parse_core #(
  parameter int MAX_SECTION_LENGTH = 1021
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  input  logic [7:0]       wanted_service_type,
  output sdt_pkg::result_t res
);

  localparam int PW = $clog2(MAX_SECTION_LENGTH + 1);
  localparam logic [11:0] MaxLen = 12'(MAX_SECTION_LENGTH);

  logic [PW-1:0]     byte_position, byte_position_next;
  logic [PW-1:0]     section_end, section_end_next;
  sdt_pkg::phase_t   parse_phase, parse_phase_next;
  logic [15:0]       current_service, current_service_next;
  logic [11:0]       loop_remaining, loop_remaining_next;
  logic [7:0]        descriptor_tag, descriptor_tag_next;
  logic [7:0]        descriptor_length, descriptor_length_next;
  logic [7:0]        descriptor_offset, descriptor_offset_next;
  logic [7:0]        provider_name_length, provider_name_length_next;
  logic [7:0]        name_remaining, name_remaining_next;
  logic              type_selected, type_selected_next;

  logic [11:0]       len;
  logic [11:0]       need;
  logic [8:0]        name_len_at;
  logic [7:0]        off_next;
  logic [7:0]        name_dec;
  logic [PW-1:0]     pos_inc;
  logic              final_byte;

  assign len         = {data_byte[3:0] & 4'h0, 4'h0, 4'h0} | {section_end[3:0], data_byte};
  assign need        = {4'h0, data_byte} + 12'd2;
  assign name_len_at = {1'b0, provider_name_length} + 9'd2;
  assign off_next    = descriptor_offset + 8'd1;
  assign name_dec    = name_remaining - 8'd1;
  assign pos_inc     = byte_position + PW'(1);
  assign final_byte  = (pos_inc == section_end);

  always_comb begin
    byte_position_next        = byte_position;
    section_end_next          = section_end;
    parse_phase_next          = parse_phase;
    current_service_next      = current_service;
    loop_remaining_next       = loop_remaining;
    descriptor_tag_next       = descriptor_tag;
    descriptor_length_next    = descriptor_length;
    descriptor_offset_next    = descriptor_offset;
    provider_name_length_next = provider_name_length;
    name_remaining_next       = name_remaining;
    type_selected_next        = type_selected;
    res                       = '0;
    res.kind                  = sdt_pkg::KIND_NAME;

    if (first_byte) begin
      // restart: abandon whatever parse is in progress
      byte_position_next  = PW'(1);
      section_end_next    = '0;
      parse_phase_next    = sdt_pkg::PH_HDR;
      loop_remaining_next = '0;
      name_remaining_next = '0;
      type_selected_next  = 1'b0;
    end else if (parse_phase == sdt_pkg::PH_HDR) begin
      byte_position_next = pos_inc;
      if (byte_position == PW'(1)) begin
        section_end_next = PW'(data_byte[3:0] & sdt_pkg::LEN_NIBBLE_MASK[3:0]);
      end else if (byte_position == PW'(2)) begin
        if (len > MaxLen || len < sdt_pkg::MIN_SECTION_LENGTH) begin
          parse_phase_next = sdt_pkg::PH_IDLE;
          res.valid        = 1'b1;
          res.kind         = sdt_pkg::KIND_ERROR;
          res.last         = 1'b1;
        end else begin
          section_end_next = PW'(len - 12'd1);
        end
      end else if (byte_position >= PW'(sdt_pkg::FIRST_SVC_BYTE_POS)) begin
        parse_phase_next = sdt_pkg::PH_SID_HI;
      end
    end else if (parse_phase != sdt_pkg::PH_IDLE && parse_phase != sdt_pkg::PH_DONE) begin
      if (byte_position >= section_end) begin
        // CRC reached: drop everything up to the next section start
        parse_phase_next = sdt_pkg::PH_DONE;
      end else begin
        byte_position_next = pos_inc;
        case (parse_phase)
          sdt_pkg::PH_SID_HI: begin
            current_service_next = {data_byte, 8'h00};
            parse_phase_next     = sdt_pkg::PH_SID_LO;
          end
          sdt_pkg::PH_SID_LO: begin
            current_service_next = {current_service[15:8], data_byte};
            parse_phase_next     = sdt_pkg::PH_FLAGS;
          end
          sdt_pkg::PH_FLAGS: begin
            parse_phase_next = sdt_pkg::PH_LOOP_HI;
          end
          sdt_pkg::PH_LOOP_HI: begin
            loop_remaining_next = {data_byte[3:0], 8'h00};
            parse_phase_next    = sdt_pkg::PH_LOOP_LO;
          end
          sdt_pkg::PH_LOOP_LO: begin
            loop_remaining_next = {loop_remaining[11:8], data_byte};
            parse_phase_next    = ({loop_remaining[11:8], data_byte} != 12'd0) ?
                                  sdt_pkg::PH_TAG : sdt_pkg::PH_SID_HI;
          end
          sdt_pkg::PH_TAG: begin
            descriptor_tag_next = data_byte;
            parse_phase_next    = sdt_pkg::PH_LEN;
          end
          sdt_pkg::PH_LEN: begin
            descriptor_length_next    = data_byte;
            // clamp at zero when the descriptor overruns the loop
            loop_remaining_next       = (loop_remaining > need) ?
                                        (loop_remaining - need) : 12'd0;
            descriptor_offset_next    = '0;
            provider_name_length_next = '0;
            name_remaining_next       = '0;
            type_selected_next        = 1'b0;
            if (data_byte == 8'd0) begin
              parse_phase_next = (loop_remaining <= need) ?
                                 sdt_pkg::PH_SID_HI : sdt_pkg::PH_TAG;
            end else begin
              parse_phase_next = sdt_pkg::PH_BODY;
            end
          end
          sdt_pkg::PH_BODY: begin
            if (descriptor_tag == sdt_pkg::SVC_DESC_TAG) begin
              if (descriptor_offset == 8'd0) begin
                type_selected_next = (data_byte == wanted_service_type);
              end else if (descriptor_offset == 8'd1) begin
                provider_name_length_next = data_byte;
              end else if ({1'b0, descriptor_offset} == name_len_at) begin
                name_remaining_next = data_byte;
                if (type_selected && data_byte == 8'd0) begin
                  res.valid      = 1'b1;
                  res.kind       = sdt_pkg::KIND_EMPTY;
                  res.service_id = current_service;
                  res.last       = 1'b1;
                end
              end else if ({1'b0, descriptor_offset} > name_len_at &&
                           name_remaining != 8'd0) begin
                name_remaining_next = name_dec;
                if (type_selected) begin
                  res.valid      = 1'b1;
                  res.kind       = sdt_pkg::KIND_NAME;
                  res.service_id = current_service;
                  res.name_byte  = data_byte;
                  res.last       = (name_dec == 8'd0) ||
                                   (off_next == descriptor_length) || final_byte;
                end
              end
            end
            descriptor_offset_next = off_next;
            if (off_next == descriptor_length) begin
              parse_phase_next = (loop_remaining == 12'd0) ?
                                 sdt_pkg::PH_SID_HI : sdt_pkg::PH_TAG;
            end
          end
          default: begin
            parse_phase_next = sdt_pkg::PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position        <= '0;
      section_end          <= '0;
      parse_phase          <= sdt_pkg::PH_IDLE;
      current_service      <= '0;
      loop_remaining       <= '0;
      descriptor_tag       <= '0;
      descriptor_length    <= '0;
      descriptor_offset    <= '0;
      provider_name_length <= '0;
      name_remaining       <= '0;
      type_selected        <= 1'b0;
    end else if (advance) begin
      byte_position        <= byte_position_next;
      section_end          <= section_end_next;
      parse_phase          <= parse_phase_next;
      current_service      <= current_service_next;
      loop_remaining       <= loop_remaining_next;
      descriptor_tag       <= descriptor_tag_next;
      descriptor_length    <= descriptor_length_next;
      descriptor_offset    <= descriptor_offset_next;
      provider_name_length <= provider_name_length_next;
      name_remaining       <= name_remaining_next;
      type_selected        <= type_selected_next;
    end
  end

endmodule

@@ hdl/sdt_out_stage.sv @@
`timescale 1ns / 1ps
// Result register: holds one result item until the consumer takes it
module sdt_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sdt_pkg::result_t res,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       kind,
  output logic [15:0]      service_id,
  output logic [7:0]       name_byte,
  output logic             last
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind       <= res.kind;
      service_id <= res.service_id;
      name_byte  <= res.name_byte;
      last       <= res.last;
    end
  end

endmodule
